// ----- design/mks_pkg.sv -----
package mks_pkg;

   localparam int ROWS_DEFAULT = 4;
   localparam int COLS_DEFAULT = 4;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 64;
   localparam int REG_SEL_LSB = 3;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 16;

   localparam logic [1:0] REG_DEBOUNCE    = 2'd0;
   localparam logic [1:0] REG_KEYMAP_LOW  = 2'd1;
   localparam logic [1:0] REG_KEYMAP_HIGH = 2'd2;

   localparam logic [15:0] DEBOUNCE_RESET    = 16'd20;
   localparam logic [63:0] KEYMAP_LOW_RESET  = 64'h0706_0504_0302_0100;
   localparam logic [63:0] KEYMAP_HIGH_RESET = 64'h0F0E_0D0C_0B0A_0908;

   localparam logic [1:0] PH_SCAN     = 2'd0;
   localparam logic [1:0] PH_DEBOUNCE = 2'd1;
   localparam logic [1:0] PH_RELEASE  = 2'd2;

   typedef struct packed {
      logic [15:0] debounce_ticks;
      logic [63:0] keymap_low;
      logic [63:0] keymap_high;
   } cfg_type;

   typedef struct packed {
      logic [1:0] scan_phase;
      logic [7:0] key_code;
      logic       key_valid;
      logic [3:0] row_drive;
   } result_type;

endpackage

// ----- design/matrix_keypad_scanner.sv -----
// matrix keypad scanner, debounced
// req channel: one item per scan tick, req_tdata[3:0] holds the active-low
// column levels sampled while the previously reported row is driven low.
// rsp channel: one item per req item, carrying the row pins to drive next,
// a key release flag with its mapped code, and the scan phase.
// csr port: debounce_ticks at 0x00, keymap_low at 0x08, keymap_high at 0x10,
// 64-bit data, pready tied high, reads return the register value.
// an accepted item is loaded into the input register, and its result is
// registered into the output register when the item advances.
// throughput: one item per cycle while the output side is not stalled; the
// scan state update is a single pass of logic between the input register and the output register.
// reset clears the scan state to row 0 scanning, empties both registers and
// restores the register defaults.
// when rsp_tready is low the output register holds its item, the input
// register still takes one more item, then req_tready drops until the
// output side moves again.
module matrix_keypad_scanner #(
   parameter int ROWS = mks_pkg::ROWS_DEFAULT,
   parameter int COLS = mks_pkg::COLS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mks_pkg::REQ_DATA_W-1:0]   req_tdata,   // col_levels[3:0], zero fill
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mks_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // row_drive[3:0], key_valid[4],
                                                         // key_code[12:5], scan_phase[14:13]
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mks_pkg::ADDR_W-1:0]       csr_paddr,
   input  logic [mks_pkg::DATA_W-1:0]       csr_pwdata,
   output logic [mks_pkg::DATA_W-1:0]       csr_prdata,
   output logic                             csr_pready
);
   import mks_pkg::*;

   cfg_type    cfg;
   result_type result;

   logic       in_valid_ff, in_valid_in;
   logic [3:0] in_cols_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;
   logic       advance;
   logic       req_take;

   mks_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   mks_scan #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .col_levels (in_cols_ff),
      .cfg        (cfg),
      .result     (result)
   );

   assign advance      = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready   = ~in_valid_ff | advance;
   assign req_take     = req_tvalid & req_tready;
   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cols_ff <= req_tdata[3:0];
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff};

endmodule

// ----- design/mks_regs.sv -----
module mks_regs (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [mks_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [mks_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [mks_pkg::DATA_W-1:0]   csr_prdata,
   output logic                         csr_pready,
   output mks_pkg::cfg_type             cfg
);
   import mks_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[ADDR_W-1:REG_SEL_LSB];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_DEBOUNCE:    cfg_in.debounce_ticks = csr_pwdata[15:0];
            REG_KEYMAP_LOW:  cfg_in.keymap_low     = csr_pwdata;
            REG_KEYMAP_HIGH: cfg_in.keymap_high    = csr_pwdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_DEBOUNCE:    csr_prdata = {48'd0, cfg_ff.debounce_ticks};
         REG_KEYMAP_LOW:  csr_prdata = cfg_ff.keymap_low;
         REG_KEYMAP_HIGH: csr_prdata = cfg_ff.keymap_high;
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
         cfg_ff.keymap_low     <= KEYMAP_LOW_RESET;
         cfg_ff.keymap_high    <= KEYMAP_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/mks_scan.sv -----
module mks_scan #(
   parameter int ROWS = mks_pkg::ROWS_DEFAULT,
   parameter int COLS = mks_pkg::COLS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [3:0]          col_levels,
   input  mks_pkg::cfg_type    cfg,
   output mks_pkg::result_type result
);
   import mks_pkg::*;

   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int N_CHK  = (COLS < 4) ? COLS : 4;
   localparam int KEY_W  = 7;

   logic [1:0]       phase_ff, phase_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [1:0]       hit_ff, hit_in;
   logic [15:0]      count_ff, count_in;
   logic [15:0]      count_inc;
   logic             found;
   logic [1:0]       found_col;
   logic [KEY_W-1:0] key_num;
   logic [127:0]     keymap_all;
   logic             key_valid;
   logic [7:0]       key_code;

   // first low column, lowest index wins
   always_comb begin
      found     = 1'b0;
      found_col = 2'd0;
      for (int c = N_CHK - 1; c >= 0; c--) begin
         if (!col_levels[c]) begin
            found     = 1'b1;
            found_col = 2'(c);
         end
      end
   end

   assign count_inc  = count_ff + 16'd1;
   assign keymap_all = {cfg.keymap_high, cfg.keymap_low};
   assign key_num    = KEY_W'(row_ff) * KEY_W'(COLS) + KEY_W'(hit_ff);

   always_comb begin
      phase_in  = phase_ff;
      row_in    = row_ff;
      hit_in    = hit_ff;
      count_in  = count_ff;
      key_valid = 1'b0;
      key_code  = 8'd0;
      case (phase_ff)
         PH_DEBOUNCE: begin
            count_in = count_inc;
            if (count_inc >= cfg.debounce_ticks) begin
               phase_in = PH_RELEASE;
            end
         end
         PH_RELEASE: begin
            if (col_levels[hit_ff]) begin
               key_valid = 1'b1;
               key_code  = keymap_all[{key_num[3:0], 3'd0} +: 8];
               phase_in  = PH_SCAN;
               row_in    = '0;
            end
         end
         default: begin
            if (found) begin
               hit_in   = found_col;
               count_in = 16'd0;
               phase_in = (cfg.debounce_ticks == 16'd0) ? PH_RELEASE : PH_DEBOUNCE;
            end else begin
               phase_in = PH_SCAN;
               row_in   = (32'(row_ff) + 32'd1 >= 32'(ROWS)) ? '0 : row_ff + ROW_W'(1);
            end
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         result.row_drive[i] = !(32'(row_in) == i);
      end
      result.key_valid  = key_valid;
      result.key_code   = key_code;
      result.scan_phase = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SCAN;
         row_ff   <= '0;
         hit_ff   <= 2'd0;
         count_ff <= 16'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         row_ff   <= row_in;
         hit_ff   <= hit_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- design/mks_check.sv -----
module mks_check (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mks_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import mks_pkg::*;

   // stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // a release restarts the scan at row 0
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[14:13] == PH_SCAN && rsp_tdata[3:0] == 4'b1110)
      else $error("key release without scan restart at row 0");

   // code is zero without a release
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[4] |-> rsp_tdata[12:5] == 8'd0)
      else $error("key code set without release");

   // at most one row driven low, phase code in use
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones(~rsp_tdata[3:0]) <= 1 && rsp_tdata[14:13] != 2'd3
         && rsp_tdata[15] == 1'b0)
      else $error("bad row drive or phase");

endmodule

bind matrix_keypad_scanner mks_check u_mks_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
